### rtl/ige_pkg.sv
package ige_pkg;

    localparam int DEF_NUM_VALUES  = 8;
    localparam int DEF_NUM_CLASSES = 8;
    localparam int DEF_MAX_ROWS    = 65536;

    localparam int CODE_W   = 3;
    localparam int OUT_W    = 18;
    localparam int ROWCNT_W = 17;
    localparam int FRAC_W   = 16;
    localparam int MANT_W   = 32;

    localparam logic [OUT_W-1:0] OUT_SAT = '1;

endpackage

### rtl/ige_ram.sv
module ige_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/ige_xlgx.sv
module ige_xlgx import ige_pkg::*; #(
    parameter int CNT_W = 17,
    localparam int POS_W = $clog2(CNT_W),
    localparam int LG_W  = POS_W + FRAC_W,
    localparam int LW    = CNT_W + LG_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] x,
    output logic             busy,
    output logic             done,
    output logic [LW-1:0]    result
);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_SQ   = 2'd1;
    localparam logic [1:0] L_MUL  = 2'd2;
    localparam int ITER_W = $clog2(FRAC_W + 1);

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    x_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [MANT_W-1:0]   m_reg, m_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [ITER_W-1:0]   iter_reg;
    logic                done_reg;
    logic [LW-1:0]       result_reg;
    logic [POS_W-1:0]    lead;
    logic [CNT_W+MANT_W-2:0] norm;
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     sq_top;

    // leading one position
    always_comb
    begin
        lead = '0;
        for (int k = 0; k < CNT_W; k++)
        begin
            if (x[k])
            begin
                lead = POS_W'(k);
            end
        end
    end

    assign norm   = {x, {(MANT_W-1){1'b0}}} >> lead;
    assign sq     = m_reg * m_reg;
    assign sq_top = sq[2*MANT_W-1:MANT_W-1];

    always_comb
    begin
        if (sq_top[MANT_W])
        begin
            m_next    = sq_top[MANT_W:1];
            frac_next = {frac_reg[FRAC_W-2:0], 1'b1};
        end
        else
        begin
            m_next    = sq_top[MANT_W-1:0];
            frac_next = {frac_reg[FRAC_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (start && (x != '0))
                begin
                    state_next = L_SQ;
                end
            end
            L_SQ:
            begin
                if (iter_reg == ITER_W'(FRAC_W - 1))
                begin
                    state_next = L_MUL;
                end
            end
            L_MUL:   state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == L_IDLE) && start && (x == '0)) ||
                         (state_reg == L_MUL);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                x_reg      <= x;
                pos_reg    <= lead;
                m_reg      <= norm[MANT_W-1:0];
                frac_reg   <= '0;
                iter_reg   <= '0;
                result_reg <= '0;
            end
            L_SQ:
            begin
                m_reg    <= m_next;
                frac_reg <= frac_next;
                iter_reg <= iter_reg + 1'b1;
            end
            L_MUL:
            begin
                result_reg <= LW'(x_reg) * LW'({pos_reg, frac_reg});
            end
            default:
            begin
                iter_reg <= '0;
            end
        endcase
    end

    assign busy   = (state_reg != L_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/ige_div.sv
module ige_div import ige_pkg::*; #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [OUT_W-1:0] quot
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;
    localparam int CW = $clog2(NUM_W + 1);

    logic [1:0]       state_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;
    logic [OUT_W-1:0] quot_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == D_FIN);
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    if (cnt_reg == CW'(NUM_W - 1))
                    begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN:
                begin
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                num_reg <= num;
                den_reg <= den;
                rem_reg <= '0;
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            D_RUN:
            begin
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                q_reg   <= {q_reg[NUM_W-2:0], fits};
                rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
            end
            D_FIN:
            begin
                quot_reg <= (|q_reg[NUM_W-1:OUT_W]) ? OUT_SAT : q_reg[OUT_W-1:0];
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### rtl/information_gain_engine_top.sv
// Information gain of one attribute over a data set. Rows come in on the slave stream, one
// per cycle while the block is loading, and bump a joint count table held in a
// single-port-read RAM (read, add one, write back, with forwarding between back-to-back
// rows). The row flagged with tlast closes the set; the block then stops taking rows and
// walks the table twice: row-major for joint and attribute terms, then column-major for
// class terms, clearing each entry on that second pass. One x*log2(x) unit serves every
// term (a zero term skips its squaring loop): one per entry on the row-major pass, and one
// per attribute total, per class total and for the row count. Two serial restoring
// divisions by the row count follow. After reset the table is zeroed by a pass over all
// NUM_VALUES*NUM_CLASSES entries before rows are taken.
module information_gain_engine_top import ige_pkg::*; #(
    parameter int NUM_VALUES  = DEF_NUM_VALUES,
    parameter int NUM_CLASSES = DEF_NUM_CLASSES,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // attribute_code[2:0], class_code[5:3]
    input  logic        s_tlast,   // last_row
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // base_entropy[17:0], cond_entropy[35:18],
                                   // info_gain[53:36], row_count[70:54]
    output logic [0:0]  m_tuser    // overflow
);

    localparam int DEPTH = NUM_VALUES * NUM_CLASSES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int VI_W  = $clog2(NUM_VALUES);
    localparam int CI_W  = $clog2(NUM_CLASSES);
    localparam int POS_W = $clog2(CNT_W);
    localparam int SUM_W = CNT_W + POS_W + FRAC_W;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_DRAIN  = 4'd2;
    localparam logic [3:0] S_P1_RD  = 4'd3;
    localparam logic [3:0] S_P1_DAT = 4'd4;
    localparam logic [3:0] S_P1_JL  = 4'd5;
    localparam logic [3:0] S_P1_AL  = 4'd6;
    localparam logic [3:0] S_P2_RD  = 4'd7;
    localparam logic [3:0] S_P2_DAT = 4'd8;
    localparam logic [3:0] S_P2_CL  = 4'd9;
    localparam logic [3:0] S_NL     = 4'd10;
    localparam logic [3:0] S_DIV1   = 4'd11;
    localparam logic [3:0] S_DIV2   = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0]       state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg;
    logic [CNT_W-1:0] rows_seen_reg;
    logic             ovf_reg;
    logic             st1_valid_reg;
    logic [AW-1:0]    st1_addr_reg;
    logic             fwd_valid_reg;
    logic [AW-1:0]    fwd_addr_reg;
    logic [CNT_W-1:0] fwd_data_reg;
    logic [VI_W-1:0]  vi_reg;
    logic [CI_W-1:0]  ci_reg;
    logic [CNT_W-1:0] tot_reg;
    logic [SUM_W-1:0] sum_joint_reg, sum_attr_reg, sum_class_reg;
    logic [OUT_W-1:0] base_reg, cond_reg;
    logic             m_tvalid_reg;
    logic [71:0]      m_tdata_reg;
    logic             m_tuser_reg;

    logic [CODE_W-1:0] attr, cls;
    logic             in_range, count_ok, acc;
    logic [AW-1:0]    row_addr, walk_addr;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [CNT_W-1:0] ram_wdata, ram_rdata, cur_count, inc_count;
    logic             last_v, last_c;
    logic [CNT_W-1:0] tot_plus;

    logic             log_start, log_busy, log_done;
    logic [CNT_W-1:0] log_x;
    logic [SUM_W-1:0] log_res;
    logic             div_start, div_done;
    logic [SUM_W-1:0] div_num;
    logic [OUT_W-1:0] div_quot, quot_use, gain;
    logic             out_free;

    assign attr     = s_tdata[2:0];
    assign cls      = s_tdata[5:3];
    assign in_range = (int'(attr) < NUM_VALUES) && (int'(cls) < NUM_CLASSES);
    assign count_ok = in_range && (rows_seen_reg < CNT_W'(MAX_ROWS));
    assign s_tready = (state_reg == S_LOAD);
    assign acc      = s_tvalid && s_tready;
    assign row_addr = AW'(int'(attr) * NUM_CLASSES + int'(cls));
    assign walk_addr = AW'(int'(vi_reg) * NUM_CLASSES + int'(ci_reg));
    assign last_v   = (vi_reg == VI_W'(NUM_VALUES - 1));
    assign last_c   = (ci_reg == CI_W'(NUM_CLASSES - 1));
    assign tot_plus = tot_reg + ram_rdata;

    // the previous row's write lands on the same edge as this row's read
    assign cur_count = (fwd_valid_reg && (fwd_addr_reg == st1_addr_reg)) ? fwd_data_reg
                                                                        : ram_rdata;
    assign inc_count = cur_count + 1'b1;

    assign ram_raddr = (state_reg == S_LOAD) ? row_addr : walk_addr;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = st1_addr_reg;
        ram_wdata = inc_count;
        if (state_reg == S_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_P2_DAT)
        begin
            ram_we    = 1'b1;
            ram_waddr = walk_addr;
            ram_wdata = '0;
        end
        else if (st1_valid_reg)
        begin
            ram_we = 1'b1;
        end
    end

    ige_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ige_xlgx #(
        .CNT_W (CNT_W)
    ) u_xlgx (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .busy   (log_busy),
        .done   (log_done),
        .result (log_res)
    );

    ige_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (rows_seen_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign quot_use = (rows_seen_reg == '0) ? '0 : div_quot;
    assign gain     = (base_reg > cond_reg) ? (base_reg - cond_reg) : '0;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        log_start  = 1'b0;
        log_x      = ram_rdata;
        div_start  = 1'b0;
        div_num    = '0;
        case (state_reg)
            S_CLR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (acc && s_tlast)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_P1_RD;
            S_P1_RD:  state_next = S_P1_DAT;
            S_P1_DAT:
            begin
                log_start  = 1'b1;
                state_next = S_P1_JL;
            end
            S_P1_JL:
            begin
                if (log_done)
                begin
                    if (last_c)
                    begin
                        log_start  = 1'b1;
                        log_x      = tot_reg;
                        state_next = S_P1_AL;
                    end
                    else
                    begin
                        state_next = S_P1_RD;
                    end
                end
            end
            S_P1_AL:
            begin
                if (log_done)
                begin
                    state_next = last_v ? S_P2_RD : S_P1_RD;
                end
            end
            S_P2_RD:  state_next = S_P2_DAT;
            S_P2_DAT:
            begin
                if (last_v)
                begin
                    log_start  = 1'b1;
                    log_x      = tot_plus;
                    state_next = S_P2_CL;
                end
                else
                begin
                    state_next = S_P2_RD;
                end
            end
            S_P2_CL:
            begin
                if (log_done)
                begin
                    if (last_c)
                    begin
                        log_start  = 1'b1;
                        log_x      = rows_seen_reg;
                        state_next = S_NL;
                    end
                    else
                    begin
                        state_next = S_P2_RD;
                    end
                end
            end
            S_NL:
            begin
                if (log_done)
                begin
                    div_start  = 1'b1;
                    div_num    = (log_res > sum_class_reg) ? (log_res - sum_class_reg) : '0;
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    div_num    = (sum_attr_reg > sum_joint_reg) ?
                                 (sum_attr_reg - sum_joint_reg) : '0;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_CLR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            rows_seen_reg <= '0;
            ovf_reg       <= 1'b0;
            st1_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            vi_reg        <= '0;
            ci_reg        <= '0;
            tot_reg       <= '0;
            sum_joint_reg <= '0;
            sum_attr_reg  <= '0;
            sum_class_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            st1_valid_reg <= acc && count_ok;
            fwd_valid_reg <= st1_valid_reg;
            if ((state_reg == S_OUT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                S_LOAD:
                begin
                    if (acc && count_ok)
                    begin
                        rows_seen_reg <= rows_seen_reg + 1'b1;
                    end
                    if (acc && in_range && !count_ok)
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                S_P1_DAT:
                begin
                    tot_reg <= tot_plus;
                end
                S_P1_JL:
                begin
                    if (log_done)
                    begin
                        sum_joint_reg <= sum_joint_reg + log_res;
                        if (!last_c)
                        begin
                            ci_reg <= ci_reg + 1'b1;
                        end
                    end
                end
                S_P1_AL:
                begin
                    if (log_done)
                    begin
                        sum_attr_reg <= sum_attr_reg + log_res;
                        tot_reg      <= '0;
                        ci_reg       <= '0;
                        vi_reg       <= last_v ? '0 : vi_reg + 1'b1;
                    end
                end
                S_P2_DAT:
                begin
                    tot_reg <= tot_plus;
                    if (!last_v)
                    begin
                        vi_reg <= vi_reg + 1'b1;
                    end
                end
                S_P2_CL:
                begin
                    if (log_done)
                    begin
                        sum_class_reg <= sum_class_reg + log_res;
                        tot_reg       <= '0;
                        vi_reg        <= '0;
                        ci_reg        <= last_c ? '0 : ci_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        rows_seen_reg <= '0;
                        ovf_reg       <= 1'b0;
                        sum_joint_reg <= '0;
                        sum_attr_reg  <= '0;
                        sum_class_reg <= '0;
                    end
                end
                default:
                begin
                    tot_reg <= tot_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        st1_addr_reg <= row_addr;
        fwd_addr_reg <= st1_addr_reg;
        fwd_data_reg <= inc_count;
        if ((state_reg == S_DIV1) && div_done)
        begin
            base_reg <= quot_use;
        end
        if ((state_reg == S_DIV2) && div_done)
        begin
            cond_reg <= quot_use;
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            m_tdata_reg <= {1'b0, ROWCNT_W'(rows_seen_reg), gain, cond_reg, base_reg};
            m_tuser_reg <= ovf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_ready_only_loading: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == S_LOAD))
        else $error("rows accepted outside load phase");

    a_rows_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rows_seen_reg <= CNT_W'(MAX_ROWS))
        else $error("row counter past limit");

    a_no_load_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD && state_reg != S_DRAIN) |-> !st1_valid_reg)
        else $error("count update pending during table walk");

    a_log_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        log_start |-> !log_busy)
        else $error("log unit started while busy");

    a_last_ends_load: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && s_tlast) |=> (state_reg == S_DRAIN))
        else $error("last row did not close the set");
`endif

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ige_pkg::*;

    localparam int NV = DEF_NUM_VALUES;
    localparam int NC = DEF_NUM_CLASSES;
    localparam int ROW_LIMIT = DEF_MAX_ROWS;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int DRAIN_CYCLES = 4000;
    localparam int HOLD_CYCLES = 5000;

    typedef struct packed {
        logic [OUT_W-1:0]    base_entropy;
        logic [OUT_W-1:0]    cond_entropy;
        logic [OUT_W-1:0]    gain_bits;
        logic [ROWCNT_W-1:0] row_count;
        logic                overflow;
    } gain_result_t;

    typedef struct {
        logic [CODE_W-1:0] attr;
        logic [CODE_W-1:0] cls;
        logic              last;
        bit                typed;
        gain_result_t      res;
    } row_vec_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;

    information_gain_engine_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // predictor state
    int unsigned  tally [NV*NC];
    int unsigned  rows_counted;
    bit           rows_dropped;
    gain_result_t gain_q[$];

    int     mismatches;
    int     cycles;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_req;
    logic   holding;
    bit     drv_typed;
    gain_result_t drv_res;
    row_vec_t dir_rows[$];

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic longint unsigned log2_q16(int unsigned x);
        int unsigned pos;
        longint unsigned m;
        longint unsigned frac;
        pos = 0;
        frac = 0;
        while (pos < 31 && (x >> (pos + 1)) != 0)
            pos++;
        m = longint'(x) << (31 - pos);
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (longint'(pos) << 16) | frac;
    endfunction

    function automatic longint unsigned xlogx(int unsigned x);
        if (x == 0)
            return 0;
        return longint'(x) * log2_q16(x);
    endfunction

    function automatic longint unsigned entropy_div(longint unsigned pos_sum,
                                                    longint unsigned neg_sum,
                                                    int unsigned n);
        longint unsigned q;
        if (neg_sum >= pos_sum || n == 0)
            return 0;
        q = (pos_sum - neg_sum) / n;
        return (q > 64'h3FFFF) ? 64'h3FFFF : q;
    endfunction

    function automatic void clear_tally();
        foreach (tally[i])
            tally[i] = 0;
        rows_counted = 0;
        rows_dropped = 0;
    endfunction

    // folds one accepted row in; returns 1 with the result when the set closes
    function automatic bit account_row(logic [CODE_W-1:0] a, logic [CODE_W-1:0] c,
                                       logic last, output gain_result_t r);
        longint unsigned s_joint, s_attr, s_class, b, h;
        int unsigned tot;
        s_joint = 0;
        s_attr = 0;
        s_class = 0;
        r = '0;
        if (a < NV && c < NC)
        begin
            if (rows_counted < ROW_LIMIT)
            begin
                tally[a*NC + c]++;
                rows_counted++;
            end
            else
                rows_dropped = 1;
        end
        if (!last)
            return 0;
        for (int i = 0; i < NV; i++)
        begin
            tot = 0;
            for (int j = 0; j < NC; j++)
            begin
                tot += tally[i*NC + j];
                s_joint += xlogx(tally[i*NC + j]);
            end
            s_attr += xlogx(tot);
        end
        for (int j = 0; j < NC; j++)
        begin
            tot = 0;
            for (int i = 0; i < NV; i++)
                tot += tally[i*NC + j];
            s_class += xlogx(tot);
        end
        b = entropy_div(xlogx(rows_counted), s_class, rows_counted);
        h = entropy_div(s_attr, s_joint, rows_counted);
        r.base_entropy = b[OUT_W-1:0];
        r.cond_entropy = h[OUT_W-1:0];
        r.gain_bits    = (b > h) ? OUT_W'(b - h) : '0;
        r.row_count    = rows_counted[ROWCNT_W-1:0];
        r.overflow     = rows_dropped;
        clear_tally();
        return 1;
    endfunction

    // input monitor
    always @(posedge clk)
    begin
        gain_result_t r;
        if (rst_n && s_tvalid && s_tready)
        begin
            if (account_row(s_tdata[2:0], s_tdata[5:3], s_tlast, r))
                gain_q = {gain_q, (drv_typed ? drv_res : r)};
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        gain_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.base_entropy = m_tdata[17:0];
            got.cond_entropy = m_tdata[35:18];
            got.gain_bits    = m_tdata[53:36];
            got.row_count    = m_tdata[70:54];
            got.overflow     = m_tuser[0];
            if (gain_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", got);
            end
            else
            begin
                want = gain_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    initial
    begin
        holding <= 1'b0;
        wait (hold_req);
        @(negedge clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holding <= 1'b0;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_row(logic [CODE_W-1:0] a, logic [CODE_W-1:0] c, logic last,
                            bit typed = 0, gain_result_t res = '0);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {2'b00, c, a};
        s_tlast   <= last;
        drv_typed <= typed;
        drv_res   <= res;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_set(output int n_sent);
        int len, mode;
        logic [CODE_W-1:0] a, c, fixed_a, fixed_c;
        logic [CODE_W-1:0] perm [8];
        len = ($urandom_range(9) == 0) ? $urandom_range(300, 25) : $urandom_range(24, 1);
        n_sent = len;
        mode = $urandom_range(4);
        fixed_a = CODE_W'($urandom);
        fixed_c = CODE_W'($urandom);
        foreach (perm[i])
            perm[i] = CODE_W'($urandom);
        for (int k = 0; k < len; k++)
        begin
            a = CODE_W'($urandom);
            c = CODE_W'($urandom);
            case (mode)
                1: a = fixed_a;
                2: c = fixed_c;
                3: c = perm[a];
                4:
                begin
                    a = a & 3'b001;
                    c = c & 3'b011;
                end
                default: ;
            endcase
            send_row(a, c, k == len - 1);
        end
    endtask

    task automatic run_phase(int idle, int stall, int n_items, bit pause_first);
        int sent;
        if (pause_first)
        begin
            s_tvalid <= 1'b0;
            wait (gain_q.size() == 0);
            @(negedge clk);
        end
        send_idle_pct = idle;
        recv_stall_pct = stall;
        sent = 0;
        while (sent < n_items)
        begin
            int n_rows;
            send_random_set(n_rows);
            sent += n_rows;
        end
    endtask

    function automatic row_vec_t mk(int a, int c, int last, bit typed = 0,
                                    int b = 0, int h = 0, int g = 0, int n = 0);
        row_vec_t v;
        v.attr = CODE_W'(a);
        v.cls = CODE_W'(c);
        v.last = 1'(last);
        v.typed = typed;
        v.res = '{OUT_W'(b), OUT_W'(h), OUT_W'(g), ROWCNT_W'(n), 1'b0};
        return v;
    endfunction

    initial
    begin
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        drv_typed = 0;
        drv_res = '0;
        clear_tally();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single row, all-ones classes vs all-zero, pure column, pure diagonal
        dir_rows = {dir_rows, mk(3, 5, 1, 1, 0, 0, 0, 1)};
        dir_rows = {dir_rows, mk(0, 0, 0)};
        dir_rows = {dir_rows, mk(7, 7, 1, 1, 65536, 0, 65536, 2)};
        for (int i = 0; i < 8; i++)
            dir_rows = {dir_rows, mk(2, i, i == 7, i == 7, 196608, 196608, 0, 8)};
        for (int i = 0; i < 8; i++)
            dir_rows = {dir_rows, mk(i, i, i == 7, i == 7, 196608, 0, 196608, 8)};
        dir_rows = {dir_rows, mk(1, 2, 0)};
        dir_rows = {dir_rows, mk(1, 3, 0)};
        dir_rows = {dir_rows, mk(4, 2, 1)};
        foreach (dir_rows[i])
            send_row(dir_rows[i].attr, dir_rows[i].cls, dir_rows[i].last,
                     dir_rows[i].typed, dir_rows[i].res);

        run_phase(0, 0, 400, 0);
        run_phase(85, 0, 400, 1);
        run_phase(0, 85, 380, 0);
        hold_req = 1;
        run_phase(0, 0, 50, 0);
        run_phase(28, 28, 400, 1);

        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        wait (gain_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
